### design/drp_pkg.sv
package drp_pkg;

   localparam int DEF_MAX_RECORDS = 6;
   localparam int DEF_MAX_LENGTH  = 1024;
   localparam int DIGEST_W        = 18;

   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_END   = 2'd1;
   localparam logic [1:0] MODE_BATCH = 2'd2;

   localparam logic [7:0] CH_OPEN  = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_VIB   = 8'h76;

   typedef struct packed {
      logic [1:0] mode;
      logic       msg_type;
      logic [7:0] data_byte;
      logic [7:0] next_byte;
      logic       next_valid;
      logic [7:0] after_next_byte;
      logic       after_next_valid;
   } req_item_type;

   typedef struct packed {
      logic       in_text;
      logic       in_option;
      logic       in_short_code;
      logic       in_value;
      logic       graceful_end;
      logic       acc_vibrate;
      logic [1:0] skip_count;
      logic [1:0] acc_type;
   } flags_type;

endpackage

### design/drp_step.sv
module drp_step import drp_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS,
   parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
   localparam int POS_W = $clog2(MAX_LENGTH + 1),
   localparam int CNT_W = $clog2(MAX_RECORDS + 1),
   localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
   input  req_item_type        item,
   input  flags_type           cur_flags,
   input  logic [POS_W-1:0]    cur_pos,
   input  logic [CNT_W-1:0]    cur_count,
   input  logic [DIGEST_W-1:0] cur_digest,
   input  logic [POS_W-1:0]    cur_start,
   input  logic [POS_W-1:0]    cur_end,
   output flags_type           nxt_flags,
   output logic [POS_W-1:0]    nxt_pos,
   output logic [CNT_W-1:0]    nxt_count,
   output logic [DIGEST_W-1:0] nxt_digest,
   output logic [POS_W-1:0]    nxt_start,
   output logic [POS_W-1:0]    nxt_end,
   output logic                emit,
   output logic [IDX_W-1:0]    rec_index,
   output logic [1:0]          rec_type,
   output logic [DIGEST_W-1:0] rec_digest,
   output logic                rec_vibrate,
   output logic [POS_W-1:0]    rec_start,
   output logic [POS_W-1:0]    rec_end
);

   logic [1:0] mtype;
   logic       room;
   logic       bar_pair;
   logic       av_other;
   logic       av_comma;

   assign mtype    = {1'b0, item.msg_type} + 2'd1;
   assign room     = cur_count < CNT_W'(MAX_RECORDS);
   assign bar_pair = (item.data_byte == CH_BAR) && item.next_valid && (item.next_byte == CH_BAR);
   assign av_other = item.after_next_valid && (item.after_next_byte != CH_BAR)
                     && (item.after_next_byte != CH_COMMA);
   assign av_comma = item.after_next_valid && (item.after_next_byte == CH_COMMA);

   assign rec_index   = cur_count[IDX_W-1:0];
   assign rec_digest  = cur_digest;
   assign rec_vibrate = cur_flags.acc_vibrate;
   assign rec_start   = cur_start;

   always_comb begin
      nxt_flags = cur_flags;
      nxt_pos   = cur_pos;
      nxt_count = cur_count;
      nxt_digest = cur_digest;
      nxt_start = cur_start;
      nxt_end   = cur_end;
      emit      = 1'b0;
      rec_type  = cur_flags.acc_type;
      rec_end   = cur_end;
      case (item.mode)
         MODE_BATCH: begin
            nxt_flags  = '0;
            nxt_pos    = '0;
            nxt_count  = '0;
            nxt_digest = '0;
            nxt_start  = '0;
            nxt_end    = '0;
         end
         MODE_END: begin
            if (cur_pos == '0) rec_type = mtype;
            if (cur_flags.in_text) rec_end = cur_pos;
            if (!cur_flags.graceful_end && room) begin
               emit      = 1'b1;
               nxt_count = cur_count + CNT_W'(1);
            end
            nxt_flags  = '0;
            nxt_pos    = '0;
            nxt_digest = '0;
            nxt_start  = '0;
            nxt_end    = '0;
         end
         MODE_BYTE: begin
            if (cur_pos < POS_W'(MAX_LENGTH)) begin
               nxt_pos = cur_pos + POS_W'(1);
               if (cur_pos == '0) nxt_flags.acc_type = mtype;
               if (cur_flags.skip_count != 2'd0) begin
                  nxt_flags.skip_count = cur_flags.skip_count - 2'd1;
               end else if (item.data_byte == CH_OPEN) begin
                  nxt_flags.in_text      = 1'b1;
                  nxt_flags.graceful_end = 1'b0;
                  nxt_flags.acc_type     = mtype;
                  nxt_start              = cur_pos + POS_W'(1);
               end else if (item.data_byte == CH_CLOSE) begin
                  rec_type = nxt_flags.acc_type;
                  if (cur_flags.in_text) rec_end = cur_pos;
                  if (room) begin
                     emit      = 1'b1;
                     nxt_count = cur_count + CNT_W'(1);
                  end
                  nxt_flags.graceful_end  = 1'b1;
                  nxt_flags.in_text       = 1'b0;
                  nxt_flags.in_option     = 1'b0;
                  nxt_flags.in_short_code = 1'b0;
                  nxt_flags.in_value      = 1'b0;
                  nxt_flags.acc_vibrate   = 1'b0;
                  nxt_flags.acc_type      = 2'd0;
                  nxt_digest = '0;
                  nxt_start  = '0;
                  nxt_end    = '0;
               end else if (bar_pair && cur_flags.in_text) begin
                  nxt_flags.in_text = 1'b0;
                  nxt_end = cur_pos;
                  if (av_other) begin
                     nxt_flags.in_option  = 1'b1;
                     nxt_flags.skip_count = 2'd1;
                  end else if (av_comma) begin
                     nxt_flags.in_short_code = 1'b1;
                     nxt_flags.skip_count    = 2'd2;
                  end else begin
                     nxt_flags.skip_count = 2'd1;
                  end
               end else if (bar_pair && (cur_flags.in_option || cur_flags.in_short_code)) begin
                  nxt_flags.in_option     = 1'b0;
                  nxt_flags.in_short_code = 1'b0;
                  nxt_flags.in_value      = 1'b1;
                  nxt_flags.skip_count    = 2'd1;
               end else if (bar_pair && cur_flags.in_value) begin
                  nxt_flags.skip_count = 2'd1;
               end else if (cur_flags.in_text) begin
                  nxt_digest = cur_digest + DIGEST_W'(item.data_byte);
               end else if (cur_flags.in_option && item.data_byte == CH_VIB) begin
                  nxt_flags.acc_vibrate = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### design/drp_out_queue.sv
module drp_out_queue import drp_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop_stall,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   output logic             full
);

   logic             out_valid_ff, out_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !pop_stall) begin
         // output slot frees up: drain the skid first
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

### design/delimited_record_parser.sv
// Channel    Direction  Handshake            Payload
// request    in         req_valid/req_stall  mode, msg_type, data_byte, lookahead bytes
// response   out        rsp_valid/rsp_stall  record_index, type, digest, vibrate, offsets
//
// One request is taken per cycle while req_stall is low; its record, if any, is put in
// the response register, or in the skid slot when rsp_stall holds it. The parser state
// is updated by a single pass of logic per request. Synchronous reset clears the parser
// state, record count and both queue slots. A two-entry output queue (response register
// plus skid) absorbs rsp_stall; req_stall rises only while the skid slot holds a record.
module delimited_record_parser import drp_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS,
   parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
   localparam int POS_W = $clog2(MAX_LENGTH + 1),
   localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic                req_msg_type,
   input  logic [7:0]          req_data_byte,
   input  logic [7:0]          req_next_byte,
   input  logic                req_next_valid,
   input  logic [7:0]          req_after_next_byte,
   input  logic                req_after_next_valid,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [IDX_W-1:0]    rsp_record_index,
   output logic [1:0]          rsp_record_type,
   output logic [DIGEST_W-1:0] rsp_digest,
   output logic                rsp_vibrate,
   output logic [POS_W-1:0]    rsp_text_start,
   output logic [POS_W-1:0]    rsp_text_end
);

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int REC_W = IDX_W + 2 + DIGEST_W + 1 + 2 * POS_W;

   req_item_type        item;
   logic                req_acc;
   flags_type           flags_ff, flags_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DIGEST_W-1:0] digest_ff, digest_in;
   logic [POS_W-1:0]    start_ff, start_in;
   logic [POS_W-1:0]    end_ff, end_in;
   logic                emit;
   logic [IDX_W-1:0]    rec_index;
   logic [1:0]          rec_type;
   logic [DIGEST_W-1:0] rec_digest;
   logic                rec_vibrate;
   logic [POS_W-1:0]    rec_start;
   logic [POS_W-1:0]    rec_end;
   logic [REC_W-1:0]    rec_data;
   logic [REC_W-1:0]    rsp_data;

   assign item = '{mode: req_mode, msg_type: req_msg_type, data_byte: req_data_byte,
                   next_byte: req_next_byte, next_valid: req_next_valid,
                   after_next_byte: req_after_next_byte,
                   after_next_valid: req_after_next_valid};
   assign req_acc = req_valid && !req_stall;

   drp_step #(
      .MAX_RECORDS (MAX_RECORDS),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_step (
      .item        (item),
      .cur_flags   (flags_ff),
      .cur_pos     (pos_ff),
      .cur_count   (count_ff),
      .cur_digest  (digest_ff),
      .cur_start   (start_ff),
      .cur_end     (end_ff),
      .nxt_flags   (flags_in),
      .nxt_pos     (pos_in),
      .nxt_count   (count_in),
      .nxt_digest  (digest_in),
      .nxt_start   (start_in),
      .nxt_end     (end_in),
      .emit        (emit),
      .rec_index   (rec_index),
      .rec_type    (rec_type),
      .rec_digest  (rec_digest),
      .rec_vibrate (rec_vibrate),
      .rec_start   (rec_start),
      .rec_end     (rec_end)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= '0;
         pos_ff    <= '0;
         count_ff  <= '0;
         digest_ff <= '0;
         start_ff  <= '0;
         end_ff    <= '0;
      end else if (req_acc) begin
         flags_ff  <= flags_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         digest_ff <= digest_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
      end
   end

   assign rec_data = {rec_index, rec_type, rec_digest, rec_vibrate, rec_start, rec_end};

   drp_out_queue #(
      .WIDTH (REC_W)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_acc && emit),
      .push_data (rec_data),
      .pop_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (req_stall)
   );

   assign {rsp_record_index, rsp_record_type, rsp_digest, rsp_vibrate,
           rsp_text_start, rsp_text_end} = rsp_data;

endmodule

### design/drp_checker.sv
module drp_checker import drp_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS,
   parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
   localparam int POS_W = $clog2(MAX_LENGTH + 1),
   localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [IDX_W-1:0]    rsp_record_index,
   input logic [1:0]          rsp_record_type,
   input logic [DIGEST_W-1:0] rsp_digest,
   input logic [POS_W-1:0]    rsp_text_start,
   input logic [POS_W-1:0]    rsp_text_end
);

   // a stalled record holds its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_record_index)
         && $stable(rsp_digest) && $stable(rsp_text_start) && $stable(rsp_text_end))
      else $error("stalled response changed");

   // backpressure only appears behind a held response
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> rsp_valid)
      else $error("request stall without a pending response");

   assert property (@(posedge clock)
      $past(reset) |-> !req_stall && !rsp_valid)
      else $error("queue not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_record_index < IDX_W'(MAX_RECORDS - 1)
         || rsp_record_index == IDX_W'(MAX_RECORDS - 1))
         && rsp_record_type != 2'd3
         && rsp_text_start <= POS_W'(MAX_LENGTH) && rsp_text_end <= POS_W'(MAX_LENGTH))
      else $error("response field out of range");

endmodule

bind delimited_record_parser drp_checker #(
   .MAX_RECORDS (MAX_RECORDS),
   .MAX_LENGTH  (MAX_LENGTH)
) u_drp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_record_index (rsp_record_index),
   .rsp_record_type  (rsp_record_type),
   .rsp_digest       (rsp_digest),
   .rsp_text_start   (rsp_text_start),
   .rsp_text_end     (rsp_text_end)
);
